FILE: sv/sorted_key_frequency_counter_defines.svh
// ---------------------------------------------------------------------------
// Sorted key frequency counter assertion macros
// Shared assertion forms for the sorted key frequency counter.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_FREQUENCY_COUNTER_DEFINES_SVH
`define SORTED_KEY_FREQUENCY_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/sfc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key frequency counter package
// Table size, derived widths and the controller to datapath interface types.
// ---------------------------------------------------------------------------
package sfc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int COUNT_W     = 32;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   typedef struct packed {
      logic count_key;
      logic shift_out;
   } dp_cmd_type;

   typedef struct packed {
      logic last_entry;
   } dp_status_type;

endpackage

FILE: sv/sfc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key frequency counter controller
// Accepts keys while idle and walks the table out one entry per cycle.
// ---------------------------------------------------------------------------
module sfc_ctrl
   import sfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          final_key,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          emit_valid
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.count_key = 1'b0;
      cmd.shift_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.count_key = 1'b1;
               if (final_key) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            cmd.shift_out = 1'b1;
            if (status.last_entry) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign emit_valid = (state_ff == ST_EMIT);

endmodule

FILE: sv/sfc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key frequency counter datapath
// A row of sorted key cells with parallel compare, shift insert and unload.
// ---------------------------------------------------------------------------
module sfc_datapath
   import sfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   input  logic signed [KEY_W-1:0]   key_value,
   output dp_status_type             status,
   output logic signed [KEY_W-1:0]   head_key,
   output logic        [COUNT_W-1:0] head_count,
   output logic                      dropped
);

   logic signed [KEY_W-1:0]   key_ff   [TABLE_DEPTH];
   logic signed [KEY_W-1:0]   key_in   [TABLE_DEPTH];
   logic        [COUNT_W-1:0] count_ff [TABLE_DEPTH];
   logic        [COUNT_W-1:0] count_in [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    valid;
   logic [TABLE_DEPTH-1:0]    less;
   logic [TABLE_DEPTH-1:0]    equal;
   logic [USED_W-1:0]         used_ff;
   logic [USED_W-1:0]         used_in;
   logic                      overflow_ff;
   logic                      overflow_in;
   logic                      hit;
   logic                      full;
   logic                      insert;

   genvar g;
   for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic signed [KEY_W-1:0]   prev_key;
      logic        [COUNT_W-1:0] prev_count;
      logic signed [KEY_W-1:0]   next_key;
      logic        [COUNT_W-1:0] next_count;
      logic                      front;

      assign valid[g] = (USED_W'(g) < used_ff);
      assign less[g]  = valid[g] && (key_ff[g] < key_value);
      assign equal[g] = valid[g] && (key_ff[g] == key_value);

      if (g == 0) begin : g_first
         assign prev_key   = key_value;
         assign prev_count = COUNT_W'(1);
         assign front      = 1'b1;
      end else begin : g_inner
         assign prev_key   = key_ff[g-1];
         assign prev_count = count_ff[g-1];
         assign front      = less[g-1];
      end

      if (g == TABLE_DEPTH - 1) begin : g_last
         assign next_key   = key_ff[g];
         assign next_count = count_ff[g];
      end else begin : g_mid
         assign next_key   = key_ff[g+1];
         assign next_count = count_ff[g+1];
      end

      always_comb begin
         key_in[g]   = key_ff[g];
         count_in[g] = count_ff[g];
         if (cmd.shift_out) begin
            key_in[g]   = next_key;
            count_in[g] = next_count;
         end else if (insert && !less[g]) begin
            if (front) begin
               key_in[g]   = key_value;
               count_in[g] = COUNT_W'(1);
            end else begin
               key_in[g]   = prev_key;
               count_in[g] = prev_count;
            end
         end else if (cmd.count_key && equal[g] && (count_ff[g] != '1)) begin
            count_in[g] = count_ff[g] + COUNT_W'(1);
         end
      end

      always_ff @(posedge clock) begin
         key_ff[g]   <= key_in[g];
         count_ff[g] <= count_in[g];
      end
   end

   assign hit    = |equal;
   assign full   = (used_ff == USED_W'(TABLE_DEPTH));
   assign insert = cmd.count_key && !hit && !full;

   always_comb begin
      used_in     = used_ff;
      overflow_in = overflow_ff;
      if (cmd.shift_out) begin
         used_in = used_ff - USED_W'(1);
         if (used_ff == USED_W'(1)) begin
            overflow_in = 1'b0;
         end
      end else if (insert) begin
         used_in = used_ff + USED_W'(1);
      end else if (cmd.count_key && !hit) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         overflow_ff <= overflow_in;
      end
   end

   assign status.last_entry = (used_ff == USED_W'(1));
   assign head_key          = key_ff[0];
   assign head_count        = count_ff[0];
   assign dropped           = overflow_ff;

endmodule

FILE: sv/sorted_key_frequency_counter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted key frequency counter
// Counts occurrences of distinct signed keys and reports them in ascending
// order after the final key of a list.
// ---------------------------------------------------------------------------
// A key is taken whenever busy is low and start is high: a row of 64 cells
// compares it against every stored key at once and either bumps the matching
// count, shifts the larger entries up to make room, or, with the table full,
// drops it and raises rsp_dropped_keys. The beat that carries the final key
// starts the unload, which shifts the table out of cell zero at one result
// per cycle, with busy high until the last entry is out. The receiver cannot
// stall, so each result is valid for exactly the one cycle in which rsp_valid
// is high. The table needs no clearing pass after reset.
`include "sorted_key_frequency_counter_defines.svh"

module sorted_key_frequency_counter
   import sfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [KEY_W-1:0]   req_key_value,
   input  logic                      req_final_key,
   output logic                      rsp_valid,
   output logic signed [KEY_W-1:0]   rsp_distinct_key,
   output logic        [COUNT_W-1:0] rsp_occurrences,
   output logic                      rsp_last_entry,
   output logic                      rsp_dropped_keys
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_key  (req_final_key),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .emit_valid (rsp_valid)
   );

   sfc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .key_value  (req_key_value),
      .status     (status),
      .head_key   (rsp_distinct_key),
      .head_count (rsp_occurrences),
      .dropped    (rsp_dropped_keys)
   );

   assign rsp_last_entry = rsp_valid && status.last_entry;

   `SFC_ASSERT_NEXT(a_final_starts_emit, clock, reset, start && !busy && req_final_key, rsp_valid)
   `SFC_ASSERT_NEXT(a_emit_continues, clock, reset, rsp_valid && !rsp_last_entry, rsp_valid)
   `SFC_ASSERT_NEXT(a_last_ends_emit, clock, reset, rsp_valid && rsp_last_entry, !busy)
   `SFC_ASSERT_NOW(a_emit_holds_off_keys, clock, reset, rsp_valid, busy)

endmodule
